FILE: src/valve_stuck_fault_monitor_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the valve stuck fault monitor.
// Both sample on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef VALVE_STUCK_FAULT_MONITOR_CORE_ASSERT_SVH
`define VALVE_STUCK_FAULT_MONITOR_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define VSFM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define VSFM_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: src/vsfm_pkg.sv
// ---------------------------------------------------------------------------
// vsfm_pkg
// Shared types, register indexes, phase codes and increment scaling helpers
// for the valve stuck fault monitor.
// ---------------------------------------------------------------------------
`default_nettype none

package vsfm_pkg;

	localparam int unsigned FLOW_W     = 20;
	localparam int unsigned FLOW_MAG_W = 19;
	localparam int unsigned LIMIT_W    = 19;
	localparam int unsigned VOL_LIM_W  = 24;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned STEP_W     = 16;
	localparam int unsigned VOL_W      = 32;
	localparam int unsigned PHASE_W    = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXH_FLOW_LIMIT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXH_VOLUME_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXH_SETTLE_MS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_FLOW_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PERSIST_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_STEP_MIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_FLOW_MAX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_PERSIST_MS = 3'd7;

	// Breath phase codes; anything above exhale means no breath
	localparam logic [PHASE_W-1:0] PH_EXH_HOLD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_EXHALE   = 3'd4;

	// Volume increment is flow * CYCLE_MS / 1000, done as a multiply by a
	// rounded-up reciprocal; the shift keeps it exact for any 19-bit flow.
	localparam int unsigned MS_PER_S  = 1000;
	localparam int unsigned INC_SHIFT = 29;

	typedef struct packed {
		logic [LIMIT_W-1:0]   exh_flow_limit;
		logic [VOL_LIM_W-1:0] exh_volume_limit;
		logic [MS_W-1:0]      exh_settle_ms;
		logic [LIMIT_W-1:0]   open_flow_limit;
		logic [MS_W-1:0]      open_persist_ms;
		logic [STEP_W-1:0]    closed_step_min;
		logic [LIMIT_W-1:0]   closed_flow_max;
		logic [MS_W-1:0]      closed_persist_ms;
	} cfg_t;

	// Per-sample qualifier results, free of tracking state
	typedef struct packed {
		logic open_ok;
		logic air_hi;
		logic oxy_hi;
		logic air_lo;
		logic oxy_lo;
		logic inhale;
		logic exh_hi;
	} cond_t;

	typedef struct packed {
		logic oxy_open;
		logic oxy_closed;
		logic air_open;
		logic air_closed;
		logic exh_open;
	} faults_t;

	function automatic logic [63:0] inc_mult(input int unsigned cycle_ms);
		return ((64'(cycle_ms) << INC_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S);
	endfunction

	function automatic int unsigned inc_mult_width(input int unsigned cycle_ms);
		return $clog2(inc_mult(cycle_ms) + 64'd1);
	endfunction

	function automatic int unsigned inc_width(input int unsigned cycle_ms);
		return FLOW_MAG_W + inc_mult_width(cycle_ms) - INC_SHIFT;
	endfunction

endpackage

`default_nettype wire

FILE: src/vsfm_qualify.sv
// ---------------------------------------------------------------------------
// vsfm_qualify
// Compares one registered sample against the limits, scales the exhale flow
// into a volume increment, and registers both for the tracking stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vsfm_qualify import vsfm_pkg::*; #(
	parameter int unsigned CYCLE_MS = 2,
	localparam int unsigned INC_W = inc_width(CYCLE_MS)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire cfg_t                     cfg,
	input  wire logic                     valid_s1,
	input  wire logic [PHASE_W-1:0]       phase_s1,
	input  wire logic                     flow_trigger_s1,
	input  wire logic signed [FLOW_W-1:0] air_flow_s1,
	input  wire logic signed [FLOW_W-1:0] oxygen_flow_s1,
	input  wire logic signed [FLOW_W-1:0] exhale_flow_s1,
	input  wire logic [STEP_W-1:0]        air_step_s1,
	input  wire logic [STEP_W-1:0]        oxygen_step_s1,
	output logic                          valid_s2,
	output cond_t                         cond_s2,
	output logic [INC_W-1:0]              inc_s2
);

	localparam int unsigned MULT_W = inc_mult_width(CYCLE_MS);
	localparam int unsigned PROD_W = FLOW_MAG_W + MULT_W;
	localparam logic [MULT_W-1:0] MULT = MULT_W'(inc_mult(CYCLE_MS));

	cond_t             cond;
	logic [PROD_W-1:0] prod;

	always_comb begin
		cond.open_ok = ((phase_s1 == PH_EXHALE) || (phase_s1 == PH_EXH_HOLD)) &&
			!flow_trigger_s1;
		cond.air_hi  = air_flow_s1 > $signed({1'b0, cfg.open_flow_limit});
		cond.oxy_hi  = oxygen_flow_s1 > $signed({1'b0, cfg.open_flow_limit});
		cond.air_lo  = (air_step_s1 >= cfg.closed_step_min) &&
			(air_flow_s1 < $signed({1'b0, cfg.closed_flow_max}));
		cond.oxy_lo  = (oxygen_step_s1 >= cfg.closed_step_min) &&
			(oxygen_flow_s1 < $signed({1'b0, cfg.closed_flow_max}));
		cond.inhale  = phase_s1 <= PH_EXH_HOLD;
		cond.exh_hi  = exhale_flow_s1 > $signed({1'b0, cfg.exh_flow_limit});
	end

	// only used when exh_hi, so the flow is positive and its low bits suffice
	assign prod = PROD_W'(exhale_flow_s1[FLOW_MAG_W-1:0]) * PROD_W'(MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			cond_s2 <= cond;
			inc_s2  <= prod[PROD_W-1:INC_SHIFT];
		end
	end

endmodule

`default_nettype wire

FILE: src/vsfm_track.sv
// ---------------------------------------------------------------------------
// vsfm_track
// Persistence counters and exhale volume integrator. Updates the tracking
// state once per sample and produces that sample's fault flags.
// ---------------------------------------------------------------------------
`default_nettype none

module vsfm_track import vsfm_pkg::*; #(
	parameter int unsigned CYCLE_MS = 2,
	localparam int unsigned INC_W = inc_width(CYCLE_MS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire cfg_t             cfg,
	input  wire cond_t            cond_s2,
	input  wire logic [INC_W-1:0] inc_s2,
	output faults_t               faults
);

	localparam logic [MS_W:0] MS_STEP = (MS_W + 1)'(CYCLE_MS);

	typedef struct packed {
		logic            fire;
		logic [MS_W-1:0] cnt;
	} cnt_upd_t;

	logic [MS_W-1:0]  oxy_open_ms_q, oxy_closed_ms_q, air_open_ms_q, air_closed_ms_q;
	logic [MS_W-1:0]  inhale_ms_q;
	logic [VOL_W-1:0] volume_q;

	cnt_upd_t         oxy_open_u, oxy_closed_u, air_open_u, air_closed_u;
	logic [MS_W-1:0]  inhale_ms_d;
	logic [VOL_W-1:0] volume_d;
	logic [VOL_W:0]   vol_sum;
	logic             exh_fire;

	function automatic logic [MS_W-1:0] add_ms(input logic [MS_W-1:0] c);
		logic [MS_W:0] s;
		s = {1'b0, c} + MS_STEP;
		return s[MS_W] ? '1 : s[MS_W-1:0];
	endfunction

	// not eligible: counter clears and nothing fires
	function automatic cnt_upd_t persist_upd(
		input logic [MS_W-1:0] c,
		input logic            eligible,
		input logic            hit,
		input logic [MS_W-1:0] persist
	);
		cnt_upd_t r;
		r.fire = 1'b0;
		r.cnt  = '0;
		if (eligible) begin
			r.cnt = hit ? add_ms(c) : '0;
			if (r.cnt >= persist) begin
				r.fire = 1'b1;
				r.cnt  = '0;
			end
		end
		return r;
	endfunction

	assign vol_sum = {1'b0, volume_q} + (VOL_W + 1)'(inc_s2);

	always_comb begin
		oxy_open_u   = persist_upd(oxy_open_ms_q, cond_s2.open_ok, cond_s2.oxy_hi,
			cfg.open_persist_ms);
		air_open_u   = persist_upd(air_open_ms_q, cond_s2.open_ok, cond_s2.air_hi,
			cfg.open_persist_ms);
		oxy_closed_u = persist_upd(oxy_closed_ms_q, 1'b1, cond_s2.oxy_lo,
			cfg.closed_persist_ms);
		air_closed_u = persist_upd(air_closed_ms_q, 1'b1, cond_s2.air_lo,
			cfg.closed_persist_ms);

		inhale_ms_d = '0;
		volume_d    = '0;
		exh_fire    = 1'b0;
		if (cond_s2.inhale) begin
			inhale_ms_d = add_ms(inhale_ms_q);
			volume_d    = volume_q;
			if (inhale_ms_d >= cfg.exh_settle_ms) begin
				if (cond_s2.exh_hi) begin
					volume_d = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
				end
				if (volume_d > VOL_W'(cfg.exh_volume_limit)) begin
					inhale_ms_d = '0;
					volume_d    = '0;
					exh_fire    = 1'b1;
				end
			end
		end
	end

	assign faults.oxy_open   = oxy_open_u.fire;
	assign faults.oxy_closed = oxy_closed_u.fire;
	assign faults.air_open   = air_open_u.fire;
	assign faults.air_closed = air_closed_u.fire;
	assign faults.exh_open   = exh_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oxy_open_ms_q   <= '0;
			oxy_closed_ms_q <= '0;
			air_open_ms_q   <= '0;
			air_closed_ms_q <= '0;
			inhale_ms_q     <= '0;
			volume_q        <= '0;
		end else if (step_en) begin
			oxy_open_ms_q   <= oxy_open_u.cnt;
			oxy_closed_ms_q <= oxy_closed_u.cnt;
			air_open_ms_q   <= air_open_u.cnt;
			air_closed_ms_q <= air_closed_u.cnt;
			inhale_ms_q     <= inhale_ms_d;
			volume_q        <= volume_d;
		end
	end

`include "valve_stuck_fault_monitor_core_assert.svh"

	// volume only grows once the settle time has run, and both clear together
	`VSFM_NEVER(a_volume_without_time, (volume_q != '0) && (inhale_ms_q == '0), "volume held with no inhale time")
	`VSFM_ASSERT(a_air_open_fire_clears, (step_en && faults.air_open) |=> (air_open_ms_q == '0), "air open counter not cleared after fault")
	`VSFM_ASSERT(a_exh_fire_in_inhale, faults.exh_open |-> cond_s2.inhale, "exhale fault outside inhale phases")

endmodule

`default_nettype wire

FILE: src/valve_stuck_fault_monitor_core.sv
// Pipeline: an accepted request passes through the input register, the qualifier
// register and the result register before its fault flags show on the output.
// Throughput: one request per clock; a stalled output holds the pipeline.
// Reset (arst_n low): pipeline valids, counters and volume clear, and all
// limit registers return to their default values.
// ---------------------------------------------------------------------------
// valve_stuck_fault_monitor_core
// Air, oxygen and exhale valve stuck open / stuck closed fault monitor.
// ---------------------------------------------------------------------------
`default_nettype none

module valve_stuck_fault_monitor_core import vsfm_pkg::*; #(
	parameter int unsigned CYCLE_MS   = 2,
	parameter int unsigned FLOW_SCALE = 100
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [PHASE_W-1:0]       phase,
	input  wire logic                     flow_trigger,
	input  wire logic signed [FLOW_W-1:0] air_flow,
	input  wire logic signed [FLOW_W-1:0] oxygen_flow,
	input  wire logic signed [FLOW_W-1:0] exhale_flow,
	input  wire logic [STEP_W-1:0]        air_step,
	input  wire logic [STEP_W-1:0]        oxygen_step,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          oxygen_open_fault,
	output logic                          oxygen_closed_fault,
	output logic                          air_open_fault,
	output logic                          air_closed_fault,
	output logic                          exhale_open_fault
);

	localparam int unsigned INC_W = inc_width(CYCLE_MS);

	localparam logic [LIMIT_W-1:0]   RST_EXH_FLOW  = LIMIT_W'(50 * FLOW_SCALE);
	localparam logic [VOL_LIM_W-1:0] RST_EXH_VOL   = VOL_LIM_W'(30 * FLOW_SCALE);
	localparam logic [LIMIT_W-1:0]   RST_OPEN_FLOW = LIMIT_W'(833 * FLOW_SCALE);

	cfg_t                     cfg_q;
	logic                     adv;
	logic                     valid_s1, valid_s2;
	logic [PHASE_W-1:0]       phase_s1;
	logic                     flow_trigger_s1;
	logic signed [FLOW_W-1:0] air_flow_s1, oxygen_flow_s1, exhale_flow_s1;
	logic [STEP_W-1:0]        air_step_s1, oxygen_step_s1;
	cond_t                    cond_s2;
	logic [INC_W-1:0]         inc_s2;
	faults_t                  faults;
	faults_t                  faults_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exh_flow_limit    <= RST_EXH_FLOW;
			cfg_q.exh_volume_limit  <= RST_EXH_VOL;
			cfg_q.exh_settle_ms     <= MS_W'(100);
			cfg_q.open_flow_limit   <= RST_OPEN_FLOW;
			cfg_q.open_persist_ms   <= MS_W'(60);
			cfg_q.closed_step_min   <= STEP_W'(333);
			cfg_q.closed_flow_max   <= LIMIT_W'(333);
			cfg_q.closed_persist_ms <= MS_W'(100);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_EXH_FLOW_LIMIT:    cfg_q.exh_flow_limit    <= cfg_data[LIMIT_W-1:0];
				CFG_EXH_VOLUME_LIMIT:  cfg_q.exh_volume_limit  <= cfg_data[VOL_LIM_W-1:0];
				CFG_EXH_SETTLE_MS:     cfg_q.exh_settle_ms     <= cfg_data[MS_W-1:0];
				CFG_OPEN_FLOW_LIMIT:   cfg_q.open_flow_limit   <= cfg_data[LIMIT_W-1:0];
				CFG_OPEN_PERSIST_MS:   cfg_q.open_persist_ms   <= cfg_data[MS_W-1:0];
				CFG_CLOSED_STEP_MIN:   cfg_q.closed_step_min   <= cfg_data[STEP_W-1:0];
				CFG_CLOSED_FLOW_MAX:   cfg_q.closed_flow_max   <= cfg_data[LIMIT_W-1:0];
				CFG_CLOSED_PERSIST_MS: cfg_q.closed_persist_ms <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless a result is waiting and the sink stalls
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			phase_s1        <= phase;
			flow_trigger_s1 <= flow_trigger;
			air_flow_s1     <= air_flow;
			oxygen_flow_s1  <= oxygen_flow;
			exhale_flow_s1  <= exhale_flow;
			air_step_s1     <= air_step;
			oxygen_step_s1  <= oxygen_step;
		end
	end

	vsfm_qualify #(
		.CYCLE_MS(CYCLE_MS)
	) u_qualify (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cfg            (cfg_q),
		.valid_s1       (valid_s1),
		.phase_s1       (phase_s1),
		.flow_trigger_s1(flow_trigger_s1),
		.air_flow_s1    (air_flow_s1),
		.oxygen_flow_s1 (oxygen_flow_s1),
		.exhale_flow_s1 (exhale_flow_s1),
		.air_step_s1    (air_step_s1),
		.oxygen_step_s1 (oxygen_step_s1),
		.valid_s2       (valid_s2),
		.cond_s2        (cond_s2),
		.inc_s2         (inc_s2)
	);

	vsfm_track #(
		.CYCLE_MS(CYCLE_MS)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(adv && valid_s2),
		.cfg    (cfg_q),
		.cond_s2(cond_s2),
		.inc_s2 (inc_s2),
		.faults (faults)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			faults_q <= faults;
		end
	end

	assign oxygen_open_fault   = faults_q.oxy_open;
	assign oxygen_closed_fault = faults_q.oxy_closed;
	assign air_open_fault      = faults_q.air_open;
	assign air_closed_fault    = faults_q.air_closed;
	assign exhale_open_fault   = faults_q.exh_open;

endmodule

`default_nettype wire

FILE: sim/tb_valve_stuck_fault_monitor_core.sv
// ---------------------------------------------------------------------------
// tb_valve_stuck_fault_monitor_core
// Self-checking bench for the valve stuck fault monitor. Breath-shaped
// request streams with random flows and steps run under several limit
// settings, among them all-zero, all-max and a held-condition run with no
// idle cycles that makes every counter climb and fire. A cycle-exact fault
// tracker predicts the five flags per request; results are checked in order
// under random stalls.
// ---------------------------------------------------------------------------
module tb_valve_stuck_fault_monitor_core;
	timeunit 1ns;
	timeprecision 1ps;

	import vsfm_pkg::*;

	localparam int unsigned CYCLE_MS   = 2;
	localparam int unsigned FLOW_SCALE = 100;

	localparam logic [PHASE_W-1:0] PH_MAND_INHALE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SPONT_INHALE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_PLATEAU      = 3'd2;
	localparam logic [PHASE_W-1:0] PH_IDLE_LO      = 3'd5;
	localparam logic [PHASE_W-1:0] PH_IDLE_HI      = 3'd7;

	localparam int FLOW_MAX = 524287;
	localparam int FLOW_MIN = -524288;
	localparam int unsigned STEP_MAX = 65535;
	localparam logic [MS_W-1:0] MS_SAT = 16'hFFFF;
	localparam longint VOL_SAT = 64'h0000_0000_FFFF_FFFF;

	// per-breath valve behavior
	localparam int VM_NORMAL = 0;
	localparam int VM_OPEN   = 1;
	localparam int VM_CLOSED = 2;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               flow_trigger;
		logic [FLOW_W-1:0]  air_flow;
		logic [FLOW_W-1:0]  oxygen_flow;
		logic [FLOW_W-1:0]  exhale_flow;
		logic [STEP_W-1:0]  air_step;
		logic [STEP_W-1:0]  oxygen_step;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	sample_t req = '0;
	logic in_stall, out_valid;
	logic oxygen_open_fault, oxygen_closed_fault, air_open_fault;
	logic air_closed_fault, exhale_open_fault;

	sample_t pending_q[$];
	faults_t expected_q[$];
	faults_t want;

	// tracker state
	cfg_t limits;
	logic [MS_W-1:0] oxy_open_ms = '0, oxy_closed_ms = '0;
	logic [MS_W-1:0] air_open_ms = '0, air_closed_ms = '0;
	logic [MS_W-1:0] inhale_ms = '0;
	logic [VOL_W-1:0] excess_vol = '0;

	int send_wait = 0, recv_wait = 0, err_cnt = 0;
	bit send_idle_on = 1'b1, recv_idle_on = 1'b1;

	valve_stuck_fault_monitor_core #(
		.CYCLE_MS(CYCLE_MS),
		.FLOW_SCALE(FLOW_SCALE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.phase(req.phase),
		.flow_trigger(req.flow_trigger),
		.air_flow(req.air_flow),
		.oxygen_flow(req.oxygen_flow),
		.exhale_flow(req.exhale_flow),
		.air_step(req.air_step),
		.oxygen_step(req.oxygen_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.oxygen_open_fault(oxygen_open_fault),
		.oxygen_closed_fault(oxygen_closed_fault),
		.air_open_fault(air_open_fault),
		.air_closed_fault(air_closed_fault),
		.exhale_open_fault(exhale_open_fault)
	);

	always #4 clk = ~clk;

	// ---------------- fault tracker ----------------

	function automatic logic [MS_W-1:0] ms_add(input logic [MS_W-1:0] c);
		int unsigned n;
		n = c + CYCLE_MS;
		return (n > MS_SAT) ? MS_SAT : n[MS_W-1:0];
	endfunction

	// returns {fire, new count}
	function automatic logic [MS_W:0] open_persist(input logic [MS_W-1:0] cnt,
			input logic eligible, input int flow);
		logic [MS_W-1:0] n;
		if (!eligible)
			return '0;
		n = (flow > int'(limits.open_flow_limit)) ? ms_add(cnt) : '0;
		if (n >= limits.open_persist_ms)
			return {1'b1, {MS_W{1'b0}}};
		return {1'b0, n};
	endfunction

	function automatic logic [MS_W:0] closed_persist(input logic [MS_W-1:0] cnt,
			input logic [STEP_W-1:0] step, input int flow);
		logic [MS_W-1:0] n;
		n = (step >= limits.closed_step_min && flow < int'(limits.closed_flow_max)) ?
			ms_add(cnt) : '0;
		if (n >= limits.closed_persist_ms)
			return {1'b1, {MS_W{1'b0}}};
		return {1'b0, n};
	endfunction

	function automatic faults_t track_faults(input sample_t s);
		faults_t f;
		logic open_ok;
		int air, oxy, exh;
		longint sum;
		f = '0;
		air = $signed(s.air_flow);
		oxy = $signed(s.oxygen_flow);
		exh = $signed(s.exhale_flow);
		open_ok = (s.phase == PH_EXH_HOLD || s.phase == PH_EXHALE) && !s.flow_trigger;
		{f.oxy_open, oxy_open_ms} = open_persist(oxy_open_ms, open_ok, oxy);
		{f.oxy_closed, oxy_closed_ms} = closed_persist(oxy_closed_ms, s.oxygen_step, oxy);
		{f.air_open, air_open_ms} = open_persist(air_open_ms, open_ok, air);
		{f.air_closed, air_closed_ms} = closed_persist(air_closed_ms, s.air_step, air);
		if (s.phase > PH_EXH_HOLD) begin
			inhale_ms = '0;
			excess_vol = '0;
		end else begin
			inhale_ms = ms_add(inhale_ms);
			if (inhale_ms >= limits.exh_settle_ms) begin
				if (exh > int'(limits.exh_flow_limit)) begin
					sum = longint'(excess_vol) + longint'(exh) * CYCLE_MS / MS_PER_S;
					excess_vol = (sum > VOL_SAT) ? VOL_SAT[VOL_W-1:0] : sum[VOL_W-1:0];
				end
				if (excess_vol > limits.exh_volume_limit) begin
					inhale_ms = '0;
					excess_vol = '0;
					f.exh_open = 1'b1;
				end
			end
		end
		return f;
	endfunction

	// ---------------- request driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				expected_q.push_back(track_faults(req));
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				req <= pending_q.pop_front();
				in_valid <= 1'b1;
				send_wait = send_idle_on ? $urandom_range(0, 14) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- result monitor ----------------

	function automatic void check_flag(input string name, input logic e, input logic g);
		if (g !== e) begin
			$error("%s: expected %0b, got %0b", name, e, g);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("fault flags with no request pending");
					err_cnt++;
				end else begin
					want = expected_q.pop_front();
					check_flag("oxygen_open_fault", want.oxy_open, oxygen_open_fault);
					check_flag("oxygen_closed_fault", want.oxy_closed, oxygen_closed_fault);
					check_flag("air_open_fault", want.air_open, air_open_fault);
					check_flag("air_closed_fault", want.air_closed, air_closed_fault);
					check_flag("exhale_open_fault", want.exh_open, exhale_open_fault);
				end
				recv_wait = recv_idle_on ? $urandom_range(0, 14) : 0;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait > 0);
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic logic [FLOW_W-1:0] flow_clamp(input int v);
		if (v > FLOW_MAX)
			return FLOW_MAX[FLOW_W-1:0];
		if (v < FLOW_MIN)
			return FLOW_MIN[FLOW_W-1:0];
		return v[FLOW_W-1:0];
	endfunction

	function automatic logic [FLOW_W-1:0] flow_above(input int lim, input int unsigned span);
		return flow_clamp(lim + int'($urandom_range(1, span)));
	endfunction

	function automatic logic [FLOW_W-1:0] flow_below(input int lim, input int unsigned span);
		return flow_clamp(lim - int'($urandom_range(1, span)));
	endfunction

	function automatic logic [FLOW_W-1:0] any_flow();
		case ($urandom_range(0, 3))
			0: return FLOW_W'($urandom);
			1: return flow_clamp(int'(limits.open_flow_limit) + int'($urandom_range(0, 200)) - 100);
			2: return flow_clamp(int'(limits.closed_flow_max) + int'($urandom_range(0, 200)) - 100);
			default: return flow_clamp(int'($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function automatic logic [FLOW_W-1:0] valve_flow(input int mode);
		if ($urandom_range(0, 15) == 0)
			return any_flow();
		case (mode)
			VM_OPEN: return flow_above(int'(limits.open_flow_limit), 4000);
			VM_CLOSED: return flow_below(int'(limits.closed_flow_max), 4000);
			default: return any_flow();
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] valve_step(input int mode);
		if (mode == VM_CLOSED)
			return STEP_W'($urandom_range(limits.closed_step_min, STEP_MAX));
		return STEP_W'($urandom);
	endfunction

	function automatic sample_t make_sample(input logic [PHASE_W-1:0] ph, input logic trig,
			input int air, input int oxy, input int exh,
			input int unsigned astep, input int unsigned ostep);
		sample_t s;
		s.phase = ph;
		s.flow_trigger = trig;
		s.air_flow = flow_clamp(air);
		s.oxygen_flow = flow_clamp(oxy);
		s.exhale_flow = flow_clamp(exh);
		s.air_step = STEP_W'(astep);
		s.oxygen_step = STEP_W'(ostep);
		return s;
	endfunction

	function automatic sample_t breath_sample(input logic [PHASE_W-1:0] ph, input logic trig,
			input int mode_a, input int mode_o, input logic leak);
		sample_t s;
		// rare glitches break up otherwise clean breaths
		s.phase = ($urandom_range(0, 29) == 0) ? PHASE_W'($urandom) : ph;
		s.flow_trigger = ($urandom_range(0, 29) == 0) ? !trig : trig;
		s.air_flow = valve_flow(mode_a);
		s.oxygen_flow = valve_flow(mode_o);
		s.air_step = valve_step(mode_a);
		s.oxygen_step = valve_step(mode_o);
		s.exhale_flow = (leak && $urandom_range(0, 7) != 0) ?
			flow_above(int'(limits.exh_flow_limit), 300000) : any_flow();
		return s;
	endfunction

	// one breath: inhale, plateau, exhale hold, exhale, maybe a no-breath gap
	task automatic queue_breath(output int n);
		int len, mode_a, mode_o;
		logic trig, leak;
		logic [PHASE_W-1:0] ph;
		n = 0;
		trig = ($urandom_range(0, 3) == 0);
		leak = $urandom_range(0, 1);
		mode_a = $urandom_range(VM_NORMAL, VM_CLOSED);
		mode_o = $urandom_range(VM_NORMAL, VM_CLOSED);
		for (int seg = 0; seg < 5; seg++) begin
			case (seg)
				0: begin
					ph = $urandom_range(0, 1) ? PH_SPONT_INHALE : PH_MAND_INHALE;
					len = $urandom_range(1, 70);
				end
				1: begin
					ph = PH_PLATEAU;
					len = $urandom_range(0, 8);
				end
				2: begin
					ph = PH_EXH_HOLD;
					len = $urandom_range(0, 8);
				end
				3: begin
					ph = PH_EXHALE;
					len = $urandom_range(1, 50);
				end
				default: begin
					ph = PHASE_W'($urandom_range(PH_IDLE_LO, PH_IDLE_HI));
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
				end
			endcase
			repeat (len)
				pending_q.push_back(breath_sample(ph, trig, mode_a, mode_o, leak));
			n += len;
		end
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_limits(input cfg_t c);
		wait_idle();
		write_reg(CFG_EXH_FLOW_LIMIT, CFG_DATA_W'(c.exh_flow_limit));
		write_reg(CFG_EXH_VOLUME_LIMIT, CFG_DATA_W'(c.exh_volume_limit));
		write_reg(CFG_EXH_SETTLE_MS, CFG_DATA_W'(c.exh_settle_ms));
		write_reg(CFG_OPEN_FLOW_LIMIT, CFG_DATA_W'(c.open_flow_limit));
		write_reg(CFG_OPEN_PERSIST_MS, CFG_DATA_W'(c.open_persist_ms));
		write_reg(CFG_CLOSED_STEP_MIN, CFG_DATA_W'(c.closed_step_min));
		write_reg(CFG_CLOSED_FLOW_MAX, CFG_DATA_W'(c.closed_flow_max));
		write_reg(CFG_CLOSED_PERSIST_MS, CFG_DATA_W'(c.closed_persist_ms));
		limits = c;
	endtask

	// mostly breaths, some pure noise; the sender drains once halfway through
	task automatic queue_traffic(input int n);
		int added, k;
		bit paused;
		added = 0;
		paused = 1'b0;
		send_idle_on = ($urandom_range(0, 3) != 0);
		recv_idle_on = ($urandom_range(0, 3) != 0);
		while (added < n) begin
			if (!paused && added >= n / 2) begin
				wait_idle();
				paused = 1'b1;
			end
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(1, 12);
				repeat (k)
					pending_q.push_back(sample_t'({$urandom, $urandom, $urandom}));
			end else begin
				queue_breath(k);
			end
			added += k;
		end
	endtask

	// ---------------- test sequence ----------------

	initial begin
		cfg_t soak;
		limits = '{
			exh_flow_limit: LIMIT_W'(50 * FLOW_SCALE),
			exh_volume_limit: VOL_LIM_W'(30 * FLOW_SCALE),
			exh_settle_ms: 16'd100,
			open_flow_limit: LIMIT_W'(833 * FLOW_SCALE),
			open_persist_ms: 16'd60,
			closed_step_min: 16'd333,
			closed_flow_max: 19'd333,
			closed_persist_ms: 16'd100
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes, every phase, thresholds at the reset limits
		pending_q.push_back(make_sample(PH_MAND_INHALE, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_sample(PH_IDLE_HI, 1, FLOW_MAX, FLOW_MIN, FLOW_MAX,
			STEP_MAX, STEP_MAX));
		pending_q.push_back(make_sample(PH_IDLE_LO, 0, FLOW_MIN, FLOW_MAX, FLOW_MIN,
			STEP_MAX, 0));
		pending_q.push_back(make_sample(PHASE_W'(PH_IDLE_LO + 1), 1, -1, 1, -1, 0, STEP_MAX));
		pending_q.push_back(make_sample(PH_EXHALE, 0, FLOW_MAX, FLOW_MAX, FLOW_MIN,
			0, STEP_MAX));
		pending_q.push_back(make_sample(PH_EXH_HOLD, 1, FLOW_MAX, FLOW_MIN, FLOW_MAX,
			STEP_MAX, 0));
		pending_q.push_back(make_sample(PH_SPONT_INHALE, 0, -1, -1, FLOW_MAX,
			STEP_MAX, STEP_MAX));
		pending_q.push_back(make_sample(PH_PLATEAU, 1, FLOW_MIN, FLOW_MIN, FLOW_MIN,
			STEP_MAX, STEP_MAX));
		pending_q.push_back(make_sample(PH_EXHALE, 0, 83301, 83300, 0, 333, 332));
		pending_q.push_back(make_sample(PH_EXH_HOLD, 0, 332, 333, 5001, 333, 333));
		queue_traffic(140);

		// everything zero: zero persistence fires on every eligible sample
		load_limits('0);
		pending_q.push_back(make_sample(PH_EXHALE, 0, 1, 0, 0, 0, 0));
		pending_q.push_back(make_sample(PH_EXH_HOLD, 1, FLOW_MAX, FLOW_MAX, 1, 0, 0));
		pending_q.push_back(make_sample(PH_MAND_INHALE, 0, FLOW_MIN, 0, FLOW_MAX,
			STEP_MAX, 0));
		pending_q.push_back(make_sample(PH_IDLE_HI, 0, FLOW_MAX, FLOW_MAX, FLOW_MAX,
			STEP_MAX, STEP_MAX));
		pending_q.push_back(make_sample(PH_EXHALE, 0, FLOW_MIN, FLOW_MIN, FLOW_MIN,
			STEP_MAX, STEP_MAX));
		pending_q.push_back(make_sample(PH_PLATEAU, 0, 0, -1, 499, 0, 0));
		pending_q.push_back(make_sample(PH_SPONT_INHALE, 1, 1, 1, 500, 1, 1));
		queue_traffic(60);

		load_limits('1);
		queue_traffic(60);

		// one condition held back to back: every counter climbs and fires
		soak = '{
			exh_flow_limit: '0,
			exh_volume_limit: 24'd5000,
			exh_settle_ms: 16'd90,
			open_flow_limit: 19'd1000,
			open_persist_ms: 16'd100,
			closed_step_min: '0,
			closed_flow_max: '1,
			closed_persist_ms: 16'd70
		};
		load_limits(soak);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		repeat (60)
			pending_q.push_back(make_sample(PH_EXH_HOLD, 0, FLOW_MAX - 1, FLOW_MAX - 1,
				FLOW_MAX, STEP_MAX, STEP_MAX));

		repeat (4) begin
			load_limits('{
				exh_flow_limit: LIMIT_W'($urandom_range(0, 60000)),
				exh_volume_limit: VOL_LIM_W'($urandom_range(0, 20000)),
				exh_settle_ms: MS_W'($urandom_range(0, 120)),
				open_flow_limit: LIMIT_W'($urandom_range(0, 120000)),
				open_persist_ms: MS_W'($urandom_range(0, 80)),
				closed_step_min: STEP_W'($urandom),
				closed_flow_max: LIMIT_W'($urandom_range(0, FLOW_MAX)),
				closed_persist_ms: MS_W'($urandom_range(0, 120))
			});
			queue_traffic(70);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS valve_stuck_fault_monitor_core");
		else
			$display("FAIL valve_stuck_fault_monitor_core");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL valve_stuck_fault_monitor_core");
		$finish;
	end

endmodule
